FILE: rtl/cmm_pkg.sv
`default_nettype none
package cmm_pkg;
	localparam int unsigned ERR_W = 46;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	typedef enum logic [1:0] {
		FUNC_ELEM   = 2'd0,
		FUNC_REPORT = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] predicted_score;
		logic [15:0] expected_score;
	} in_item_t;

	typedef struct packed {
		logic             row_kind;
		logic [2:0]       class_index;
		logic [15:0]      count_tp;
		logic [15:0]      count_fp;
		logic [15:0]      count_fn;
		logic [15:0]      count_tn;
		logic [15:0]      accuracy_q15;
		logic [15:0]      precision_q15;
		logic [15:0]      recall_q15;
		logic [15:0]      f1_q15;
		logic [ERR_W-1:0] squared_error_sum;
		logic             last;
	} out_item_t;

	// Command passed from the front end to the back end
	typedef struct packed {
		logic [1:0]  op;
		logic        upd;
		logic [15:0] pscore;
		logic [3:0]  pidx;
		logic [3:0]  eidx;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_UPD, BK_SUM, BK_PR, BK_RC, BK_AC, BK_F1, BK_EMIT,
		BK_SUMP, BK_SUMR, BK_SUMF, BK_SACC, BK_SEMIT
	} bk_state_t;
endpackage
`default_nettype wire

FILE: rtl/cmm_div.sv
`default_nettype none
// Restoring divider: quotient of num / den, one bit per cycle.
module cmm_div
	import cmm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [33:0] num,
	input  wire logic [17:0] den,
	output logic             busy,
	output logic [33:0]      quo
);
	logic [5:0]  cnt_q;
	logic [33:0] n_q;
	logic [18:0] r_q;
	logic [17:0] d_q;
	logic [18:0] r_sh;
	logic [18:0] r_sub;

	assign busy  = cnt_q != 6'd0;
	assign r_sh  = {r_q[17:0], n_q[33]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd34;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			quo <= '0;
		end else if (busy) begin
			n_q <= {n_q[32:0], 1'b0};
			if (!r_sub[18]) begin
				r_q <= r_sub;
				quo <= {quo[32:0], 1'b1};
			end else begin
				r_q <= r_sh;
				quo <= {quo[32:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cmm_front.sv
`default_nettype none
// Classifies requests and tracks the running argmax of each sample.
module cmm_front
	import cmm_pkg::*;
#(
	parameter int unsigned MAX_CLASSES = 5
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_item_t in_data,
	output logic          in_stall,
	input  wire logic [2:0] class_count,
	output logic          cmd_valid,
	output cmd_t          cmd,
	input  wire logic     cmd_full
);
	logic [3:0]  pos_q, pidx_q, eidx_q, n_act, pi, ei;
	logic [15:0] pbest_q, ebest_q, pb, eb;
	logic        take, fin, tp, te;

	always_comb begin
		if (class_count < 3'd2) n_act = 4'd2;
		else if (32'(class_count) > MAX_CLASSES) n_act = 4'(MAX_CLASSES);
		else n_act = {1'b0, class_count};
	end

	assign in_stall = cmd_full;
	assign take = in_valid && !cmd_full;
	assign tp = pos_q == 4'd0 || in_data.predicted_score > pbest_q;
	assign te = pos_q == 4'd0 || in_data.expected_score > ebest_q;
	assign pb = tp ? in_data.predicted_score : pbest_q;
	assign pi = tp ? pos_q : pidx_q;
	assign eb = te ? in_data.expected_score : ebest_q;
	assign ei = te ? pos_q : eidx_q;
	assign fin = pos_q + 4'd1 >= n_act;

	always_comb begin
		cmd_valid  = 1'b0;
		cmd.op     = in_data.func;
		cmd.upd    = 1'b0;
		cmd.pscore = pb;
		cmd.pidx   = (32'(pi) < MAX_CLASSES) ? pi : 4'd0;
		cmd.eidx   = (32'(ei) < MAX_CLASSES) ? ei : 4'd0;
		if (take) begin
			unique case (func_t'(in_data.func))
				FUNC_ELEM:   begin cmd_valid = fin; cmd.upd = fin; end
				FUNC_REPORT: cmd_valid = 1'b1;
				FUNC_CLEAR:  cmd_valid = 1'b1;
				default:     cmd_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; pidx_q <= '0; eidx_q <= '0; pbest_q <= '0; ebest_q <= '0;
		end else if (take) begin
			if (in_data.func == FUNC_CLEAR) begin
				pos_q <= '0; pidx_q <= '0; eidx_q <= '0; pbest_q <= '0; ebest_q <= '0;
			end else if (in_data.func == FUNC_ELEM) begin
				pbest_q <= pb; pidx_q <= pi; ebest_q <= eb; eidx_q <= ei;
				pos_q <= fin ? 4'd0 : pos_q + 4'd1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cmm_queue.sv
`default_nettype none
// Two-entry command queue between front and back ends.
module cmm_queue
	import cmm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wdata,
	output logic      full,
	output logic      empty,
	input  wire logic rd,
	output cmd_t      rdata
);
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cmm_back.sv
`default_nettype none
// Holds the matrix and totals, applies updates and clears, and walks out report rows.
module cmm_back
	import cmm_pkg::*;
#(
	parameter int unsigned MAX_CLASSES = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [2:0] class_count,
	input  wire logic       q_empty,
	input  wire cmd_t       q_data,
	output logic            q_rd,
	output logic            out_valid,
	output out_item_t       out_data,
	input  wire logic       out_stall
);
	localparam int unsigned NC = MAX_CLASSES * MAX_CLASSES;
	localparam int unsigned IW = $clog2(MAX_CLASSES);
	localparam int unsigned CW = $clog2(NC);

	bk_state_t st_q, st_d;
	logic [15:0] cell_q [NC];
	logic [15:0] total_q;
	logic [ERR_W-1:0] err_q;
	logic [IW-1:0] cls_q, ri_q, ci_q;
	logic [3:0] n_act;
	logic [17:0] tp_q, fp_q, fn_q, tn_q, diag_q;
	logic [15:0] pr_q, rc_q, f1_q, sacc_q;
	logic [19:0] sp_q, sr_q, sf_q;
	logic [16:0] mp_q;
	logic [31:0] sq_q, sq_d;
	logic [16:0] dlt;
	logic [CW-1:0] uk, rk;
	logic        out_v_q;
	out_item_t   out_q;
	logic        dstart, dbusy;
	logic [33:0] dnum, dquo;
	logic [17:0] dden;
	logic        dpend_q;
	logic [15:0] cv;
	logic [ERR_W:0] esum;

	cmm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .quo(dquo)
	);

	always_comb begin
		if (class_count < 3'd2) n_act = 4'd2;
		else if (32'(class_count) > MAX_CLASSES) n_act = 4'(MAX_CLASSES);
		else n_act = {1'b0, class_count};
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign uk = CW'(q_data.pidx) * CW'(MAX_CLASSES) + CW'(q_data.eidx);
	assign rk = CW'(ri_q) * CW'(MAX_CLASSES) + CW'(ci_q);
	assign cv = cell_q[rk];
	assign dlt = (q_data.pscore <= ONE_Q15) ? 17'(ONE_Q15 - q_data.pscore)
		: 17'(q_data.pscore - ONE_Q15);
	assign sq_d = dlt[16:0] * dlt[16:0];
	assign esum = {1'b0, err_q} + (ERR_W+1)'(sq_q);

	// Division setup for each ratio step; waits on the shared divider.
	always_comb begin
		dnum = '0; dden = '0;
		unique case (st_q)
			BK_PR:   begin dnum = 34'(tp_q) << 15; dden = tp_q + fp_q; end
			BK_RC:   begin dnum = 34'(tp_q) << 15; dden = tp_q + fn_q; end
			BK_AC:   begin dnum = 34'(tp_q + tn_q) << 15; dden = tp_q + tn_q + fp_q + fn_q; end
			BK_F1:   begin dnum = 34'({pr_q, 1'b0}) * 34'(rc_q);
				dden = 18'(pr_q) + 18'(rc_q); end
			BK_SUMP: begin dnum = 34'(sp_q); dden = 18'(n_act); end
			BK_SUMR: begin dnum = 34'(sr_q); dden = 18'(n_act); end
			BK_SUMF: begin dnum = 34'(sf_q); dden = 18'(n_act); end
			BK_SACC: begin dnum = 34'(diag_q) << 15; dden = 18'(total_q); end
			default: ;
		endcase
	end

	logic ratio_st;
	assign ratio_st = st_q == BK_PR || st_q == BK_RC || st_q == BK_AC || st_q == BK_F1 ||
		st_q == BK_SUMP || st_q == BK_SUMR || st_q == BK_SUMF || st_q == BK_SACC;
	assign dstart = ratio_st && !dpend_q && !dbusy;

	always_comb begin
		st_d = st_q;
		q_rd = 1'b0;
		unique case (st_q)
			BK_IDLE: if (!q_empty) begin
				unique case (func_t'(q_data.op))
					FUNC_ELEM:   st_d = BK_UPD;
					FUNC_REPORT: st_d = BK_SUM;
					default:     q_rd = 1'b1;
				endcase
			end
			BK_UPD: begin st_d = BK_IDLE; q_rd = 1'b1; end
			BK_SUM: if (ri_q == IW'(n_act - 4'd1) && ci_q == IW'(n_act - 4'd1)) st_d = BK_PR;
			BK_PR, BK_RC, BK_AC, BK_SUMP, BK_SUMR, BK_SUMF:
				if (dpend_q && !dbusy) st_d = bk_state_t'(st_q + 4'd1);
			BK_F1: if (dpend_q && !dbusy) st_d = BK_EMIT;
			BK_SACC: if (dpend_q && !dbusy) st_d = BK_SEMIT;
			BK_EMIT: if (!out_v_q || !out_stall) begin
				st_d = ({1'b0, cls_q} == n_act - 4'd1) ? BK_SUMP : BK_SUM;
			end
			BK_SEMIT: if (!out_v_q || !out_stall) begin st_d = BK_IDLE; q_rd = 1'b1; end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; out_v_q <= 1'b0; dpend_q <= 1'b0;
			total_q <= '0; err_q <= '0; cls_q <= '0; ri_q <= '0; ci_q <= '0;
			for (int k = 0; k < NC; k++) cell_q[k] <= '0;
		end else begin
			st_q <= st_d;
			if ((st_q == BK_EMIT || st_q == BK_SEMIT) && (!out_v_q || !out_stall))
				out_v_q <= 1'b1;
			else if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
			if (dstart) dpend_q <= 1'b1;
			else if (dpend_q && !dbusy) dpend_q <= 1'b0;
			unique case (st_q)
				BK_IDLE: if (!q_empty && q_data.op == FUNC_CLEAR) begin
					total_q <= '0; err_q <= '0;
					for (int k = 0; k < NC; k++) cell_q[k] <= '0;
				end else if (!q_empty && q_data.op == FUNC_REPORT) begin
					cls_q <= '0; ri_q <= '0; ci_q <= '0;
				end
				BK_UPD: if (q_data.upd && total_q != 16'hFFFF) begin
					total_q <= total_q + 16'd1;
					if (cell_q[uk] != 16'hFFFF) cell_q[uk] <= cell_q[uk] + 16'd1;
					err_q <= esum[ERR_W] ? {ERR_W{1'b1}} : esum[ERR_W-1:0];
				end
				BK_SUM: begin
					if (ci_q == IW'(n_act - 4'd1)) begin
						ci_q <= '0; ri_q <= ri_q + IW'(1);
					end else begin
						ci_q <= ci_q + IW'(1);
					end
				end
				BK_EMIT: if (!out_v_q || !out_stall) begin
					cls_q <= cls_q + IW'(1); ri_q <= '0; ci_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sq_q <= sq_d;
		unique case (st_q)
			BK_IDLE: begin
				tp_q <= '0; fp_q <= '0; fn_q <= '0; tn_q <= '0;
				if (!q_empty && q_data.op == FUNC_REPORT) begin
					diag_q <= '0; sp_q <= '0; sr_q <= '0; sf_q <= '0;
				end
			end
			BK_SUM: begin
				if (ri_q == cls_q && ci_q == cls_q) tp_q <= 18'(cv);
				else if (ri_q == cls_q) fp_q <= fp_q + 18'(cv);
				else if (ci_q == cls_q) fn_q <= fn_q + 18'(cv);
				else tn_q <= tn_q + 18'(cv);
			end
			BK_PR: if (dpend_q && !dbusy) pr_q <= (fp_q + tp_q == 0) ? ONE_Q15 : dquo[15:0];
			BK_RC: if (dpend_q && !dbusy) rc_q <= (fn_q + tp_q == 0) ? ONE_Q15 : dquo[15:0];
			BK_AC: if (dpend_q && !dbusy)
				mp_q <= (tp_q + tn_q + fp_q + fn_q == 0) ? 17'd0 : dquo[16:0];
			BK_F1: if (dpend_q && !dbusy) begin
				f1_q <= (pr_q + rc_q == 0) ? 16'd0 : dquo[15:0];
				sf_q <= sf_q + ((pr_q + rc_q == 0) ? 20'd0 : 20'(dquo[15:0]));
			end
			BK_EMIT: if (!out_v_q || !out_stall) begin
				out_q.row_kind <= 1'b0;
				out_q.class_index <= 3'(cls_q);
				out_q.count_tp <= tp_q[15:0];
				out_q.count_fp <= (fp_q > 18'hFFFF) ? 16'hFFFF : fp_q[15:0];
				out_q.count_fn <= (fn_q > 18'hFFFF) ? 16'hFFFF : fn_q[15:0];
				out_q.count_tn <= (tn_q > 18'hFFFF) ? 16'hFFFF : tn_q[15:0];
				out_q.accuracy_q15 <= mp_q[15:0];
				out_q.precision_q15 <= pr_q;
				out_q.recall_q15 <= rc_q;
				out_q.f1_q15 <= f1_q;
				out_q.squared_error_sum <= '0;
				out_q.last <= 1'b0;
				diag_q <= diag_q + tp_q;
				sp_q <= sp_q + 20'(pr_q);
				sr_q <= sr_q + 20'(rc_q);
				tp_q <= '0; fp_q <= '0; fn_q <= '0; tn_q <= '0;
			end
			BK_SUMP: if (dpend_q && !dbusy) pr_q <= dquo[15:0];
			BK_SUMR: if (dpend_q && !dbusy) rc_q <= dquo[15:0];
			BK_SUMF: if (dpend_q && !dbusy) mp_q <= dquo[16:0];
			BK_SACC: if (dpend_q && !dbusy) sacc_q <= (total_q == 0) ? 16'd0 : dquo[15:0];
			BK_SEMIT: if (!out_v_q || !out_stall) begin
				out_q.row_kind <= 1'b1;
				out_q.class_index <= '0;
				out_q.count_tp <= (diag_q > 18'hFFFF) ? 16'hFFFF : diag_q[15:0];
				out_q.count_fp <= total_q;
				out_q.count_fn <= '0;
				out_q.count_tn <= '0;
				out_q.accuracy_q15 <= sacc_q;
				out_q.precision_q15 <= pr_q;
				out_q.recall_q15 <= rc_q;
				out_q.f1_q15 <= mp_q[15:0];
				out_q.squared_error_sum <= err_q;
				out_q.last <= 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/confusion_matrix_metrics.sv
`default_nettype none
// Score elements: one per cycle while the input is not stalled; a sample's last element passes through the command
// queue and the back end's idle and update states before the matrix is updated. Report: per class, reads of all
// n*n cells, then four divisions (precision, recall, accuracy, F1) and an emit; the summary row adds four more
// divisions (three means and accuracy) and an emit. All divisions run on the shared bit-serial divider.
// Input stalls only while the two-entry command queue is full.
// Reset: asynchronous, clears matrix, totals and argmax state; class_count returns to 5.
module confusion_matrix_metrics
	import cmm_pkg::*;
#(
	parameter int unsigned MAX_CLASSES = 5
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire in_item_t  in_data,
	output logic           in_stall,
	output logic           out_valid,
	output out_item_t      out_data,
	input  wire logic      out_stall,
	input  wire logic      cfg_we,
	input  wire logic [2:0] cfg_wdata
);
	logic [2:0] cc_q;
	logic       cmd_v, q_full, q_empty, q_rd;
	cmd_t       cmd, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cc_q <= 3'd5;
		else if (cfg_we) cc_q <= cfg_wdata;
	end

	cmm_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_data(in_data),
		.in_stall(in_stall), .class_count(cc_q), .cmd_valid(cmd_v), .cmd(cmd),
		.cmd_full(q_full)
	);

	cmm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(cmd_v), .wdata(cmd), .full(q_full),
		.empty(q_empty), .rd(q_rd), .rdata(q_data)
	);

	cmm_back #(.MAX_CLASSES(MAX_CLASSES)) u_back (
		.clk(clk), .arst_n(arst_n), .class_count(cc_q), .q_empty(q_empty),
		.q_data(q_data), .q_rd(q_rd), .out_valid(out_valid), .out_data(out_data),
		.out_stall(out_stall)
	);
endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench
	import cmm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCLS = 5;
	localparam longint unsigned ERR_SAT = (64'd1 << 46) - 1;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	in_item_t  in_data;
	logic      in_stall;
	logic      out_valid;
	out_item_t out_data;
	logic      out_stall;
	logic      cfg_we;
	logic [2:0] cfg_wdata;

	confusion_matrix_metrics #(.MAX_CLASSES(NCLS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Shadow of the matrix state
	int unsigned     cells [NCLS*NCLS];
	int unsigned     sample_cnt;
	longint unsigned err_sum;
	int unsigned     elem_pos;
	int unsigned     best_p, best_p_idx, best_e, best_e_idx;
	int unsigned     class_cfg;

	out_item_t rows_due[$];
	int        errors;
	int        rows_seen;
	bit        calm;

	function automatic int unsigned active_n();
		if (class_cfg < 2) return 2;
		if (class_cfg > NCLS) return NCLS;
		return class_cfg;
	endfunction

	function automatic int unsigned frac_q15(longint unsigned num, longint unsigned den,
			int unsigned if_zero);
		if (den == 0) return if_zero;
		return int'((num << 15) / den);
	endfunction

	task automatic clear_matrix();
		foreach (cells[i]) cells[i] = 0;
		sample_cnt = 0;
		err_sum = 0;
		elem_pos = 0;
		best_p = 0;
		best_p_idx = 0;
		best_e = 0;
		best_e_idx = 0;
	endtask

	task automatic tally_element(int unsigned p, int unsigned e);
		int unsigned n, pos, k;
		longint unsigned d, sq;
		n = active_n();
		pos = elem_pos;
		if (pos == 0 || p > best_p) begin
			best_p = p;
			best_p_idx = pos;
		end
		if (pos == 0 || e > best_e) begin
			best_e = e;
			best_e_idx = pos;
		end
		if (pos + 1 >= n) begin
			if (sample_cnt < 65535) begin
				d = (best_p <= 32768) ? 32768 - best_p : best_p - 32768;
				sq = d * d;
				k = best_p_idx * NCLS + best_e_idx;
				sample_cnt++;
				if (cells[k] < 65535) cells[k]++;
				if (err_sum > ERR_SAT - sq) err_sum = ERR_SAT;
				else err_sum += sq;
			end
			elem_pos = 0;
		end else begin
			elem_pos = pos + 1;
		end
	endtask

	task automatic queue_report_rows();
		int unsigned n, pr, rc, f1;
		longint unsigned diag, sp, sr, sf, tp, fp, fn, tn, v;
		out_item_t row;
		n = active_n();
		diag = 0; sp = 0; sr = 0; sf = 0;
		for (int c = 0; c < n; c++) begin
			tp = cells[c*NCLS + c];
			fp = 0; fn = 0; tn = 0;
			for (int i = 0; i < n; i++)
				for (int m = 0; m < n; m++) begin
					v = cells[i*NCLS + m];
					if (i == c && m != c) fp += v;
					else if (i != c && m == c) fn += v;
					else if (i != c && m != c) tn += v;
				end
			pr = frac_q15(tp, tp + fp, 32768);
			rc = frac_q15(tp, tp + fn, 32768);
			f1 = (pr + rc == 0) ? 0 : int'((2 * longint'(pr) * rc) / (longint'(pr) + rc));
			diag += tp; sp += pr; sr += rc; sf += f1;
			row = '0;
			row.class_index = c[2:0];
			row.count_tp = (tp > 65535) ? 16'hFFFF : tp[15:0];
			row.count_fp = (fp > 65535) ? 16'hFFFF : fp[15:0];
			row.count_fn = (fn > 65535) ? 16'hFFFF : fn[15:0];
			row.count_tn = (tn > 65535) ? 16'hFFFF : tn[15:0];
			row.accuracy_q15 = 16'(frac_q15(tp + tn, tp + tn + fp + fn, 0));
			row.precision_q15 = pr[15:0];
			row.recall_q15 = rc[15:0];
			row.f1_q15 = f1[15:0];
			rows_due.push_back(row);
		end
		row = '0;
		row.row_kind = 1'b1;
		row.count_tp = (diag > 65535) ? 16'hFFFF : diag[15:0];
		row.count_fp = sample_cnt[15:0];
		row.accuracy_q15 = 16'(frac_q15(diag, sample_cnt, 0));
		row.precision_q15 = 16'(sp / n);
		row.recall_q15 = 16'(sr / n);
		row.f1_q15 = 16'(sf / n);
		row.squared_error_sum = err_sum[ERR_W-1:0];
		row.last = 1'b1;
		rows_due.push_back(row);
	endtask

	task automatic apply_request(in_item_t it);
		case (func_t'(it.func))
			FUNC_ELEM:   tally_element(it.predicted_score, it.expected_score);
			FUNC_REPORT: queue_report_rows();
			FUNC_CLEAR:  clear_matrix();
			default: ;
		endcase
	endtask

	task automatic send_request(in_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		apply_request(it);
	endtask

	task automatic set_class_count(logic [2:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (rows_due.size() == 0);
		repeat (60) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		class_cfg = v;
	endtask

	function automatic logic [15:0] pick_score();
		case ($urandom_range(0, 6))
			0: return 16'd0;
			1: return ONE_Q15;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(0, 4) * 8192);
			4: return 16'($urandom_range(0, 32768));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_request();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.predicted_score = pick_score();
		it.expected_score = pick_score();
		if (r < 86) it.func = FUNC_ELEM;
		else if (r < 94) it.func = FUNC_REPORT;
		else if (r < 97) it.func = FUNC_CLEAR;
		else it.func = FUNC_NONE;
		return it;
	endfunction

	task automatic note_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Row checker
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			rows_seen++;
			if (rows_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected row expected none actual %h", $time, out_data);
			end else begin
				want = rows_due.pop_front();
				note_field("row_kind", want.row_kind, out_data.row_kind);
				note_field("class_index", want.class_index, out_data.class_index);
				note_field("count_tp", want.count_tp, out_data.count_tp);
				note_field("count_fp", want.count_fp, out_data.count_fp);
				note_field("count_fn", want.count_fn, out_data.count_fn);
				note_field("count_tn", want.count_tn, out_data.count_tn);
				note_field("accuracy_q15", want.accuracy_q15, out_data.accuracy_q15);
				note_field("precision_q15", want.precision_q15, out_data.precision_q15);
				note_field("recall_q15", want.recall_q15, out_data.recall_q15);
				note_field("f1_q15", want.f1_q15, out_data.f1_q15);
				note_field("squared_error_sum", want.squared_error_sum,
					out_data.squared_error_sum);
				note_field("last", want.last, out_data.last);
			end
		end
	end

	// Receiver stall: random bursts, one long hold-off once enough rows have passed
	initial begin
		int burst;
		int hold;
		bit held;
		burst = 0;
		hold = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && rows_seen >= 30 && rows_due.size() > 0) begin
				held = 1;
				hold = 3000;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	typedef struct {
		logic [1:0]  func;
		logic [15:0] p;
		logic [15:0] e;
		bit          blank;
	} step_t;

	// blank: the summary row is that of an empty matrix
	step_t steps [] = '{
		'{FUNC_REPORT, 16'd0, 16'd0, 1'b1},
		'{FUNC_NONE, 16'hFFFF, 16'hFFFF, 1'b0},
		'{FUNC_ELEM, 16'd0, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'd0, 16'd32768, 1'b0},
		'{FUNC_ELEM, 16'd0, 16'd32768, 1'b0},
		'{FUNC_ELEM, 16'd0, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'd0, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'd100, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'd100, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'd200, 16'hFFFF, 1'b0},
		'{FUNC_ELEM, 16'd200, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'hFFFF, 16'd1, 1'b0},
		'{FUNC_REPORT, 16'd0, 16'd0, 1'b0},
		'{FUNC_ELEM, 16'd32768, 16'd5, 1'b0},
		'{FUNC_ELEM, 16'd32769, 16'd6, 1'b0},
		'{FUNC_REPORT, 16'hFFFF, 16'hFFFF, 1'b0},
		'{FUNC_CLEAR, 16'd0, 16'd0, 1'b0},
		'{FUNC_REPORT, 16'd0, 16'd0, 1'b1},
		'{FUNC_ELEM, 16'hFFFF, 16'hFFFF, 1'b0},
		'{FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 1'b0},
		'{FUNC_REPORT, 16'd0, 16'd0, 1'b1}
	};

	logic [2:0] count_plan [] = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd5};

	initial begin
		in_item_t it;
		out_item_t empty_sum;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		rows_seen = 0;
		calm = 0;
		class_cfg = 5;
		clear_matrix();
		empty_sum = '0;
		empty_sum.row_kind = 1'b1;
		empty_sum.precision_q15 = ONE_Q15;
		empty_sum.recall_q15 = ONE_Q15;
		empty_sum.f1_q15 = ONE_Q15;
		empty_sum.last = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			it.func = steps[i].func;
			it.predicted_score = steps[i].p;
			it.expected_score = steps[i].e;
			send_request(it);
			if (steps[i].blank) rows_due[rows_due.size()-1] = empty_sum;
		end

		foreach (count_plan[i]) begin
			set_class_count(count_plan[i]);
			repeat (28) send_request(random_request());
		end

		// Finish back to back with no idling
		calm = 1;
		set_class_count(3'd2);
		it = '0;
		it.func = FUNC_CLEAR;
		send_request(it);
		repeat (12) begin
			it.func = FUNC_ELEM;
			it.predicted_score = 16'($urandom);
			it.expected_score = 16'($urandom);
			send_request(it);
		end
		it.func = FUNC_REPORT;
		send_request(it);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (rows_due.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("confusion_matrix_metrics regression: pass");
		else
			$display("confusion_matrix_metrics regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("confusion_matrix_metrics regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
